[hdl/pli_pkg.sv]
package pli_pkg;

    // Table size and value width.
    localparam int NUM_CELLS  = 32;
    localparam int IDX_W      = 5;
    localparam int CNT_W      = 6;
    localparam int VAL_W      = 32;
    localparam int STEP_W     = 5;

    // Item kinds carried in tuser.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic REG_POINT_COUNT = 1'b0;

    // Query token that walks the chain of cells.
    typedef struct packed {
        logic             valid;
        logic [VAL_W-1:0] d;
        logic             first;
        logic             last;
        logic [VAL_W-1:0] yc;
        logic             hit;
        logic [VAL_W-1:0] x0;
        logic [VAL_W-1:0] x1;
        logic [VAL_W-1:0] y0;
        logic [VAL_W-1:0] y1;
    } t_tok;

    // Breakpoint write broadcast to all cells.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] x;
        logic [VAL_W-1:0] y;
    } t_wr;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

[hdl/pli_cell.sv]
module pli_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [pli_pkg::IDX_W-1:0]     i_idx,
    input  logic [pli_pkg::IDX_W-1:0]     i_last_idx,
    input  pli_pkg::t_wr                  i_wr,
    input  pli_pkg::t_tok                 i_tok,
    input  logic [pli_pkg::VAL_W-1:0]     i_nx_x,
    input  logic [pli_pkg::VAL_W-1:0]     i_nx_y,
    output logic [pli_pkg::VAL_W-1:0]     o_x,
    output logic [pli_pkg::VAL_W-1:0]     o_y,
    output pli_pkg::t_tok                 o_tok
);

    logic [pli_pkg::VAL_W-1:0] r_x;
    logic [pli_pkg::VAL_W-1:0] r_y;
    pli_pkg::t_tok             r_tok;
    pli_pkg::t_tok             n_tok;

    // Breakpoint storage for this slot.
    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.idx == i_idx)) begin
            r_x <= i_wr.x;
            r_y <= i_wr.y;
        end
    end

    // Check the passing query against this slot and the next one.
    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid) begin
            if ((i_idx == '0) && ($signed(i_tok.d) <= $signed(r_x))) begin
                n_tok.first = 1'b1;
                n_tok.yc    = r_y;
            end
            if (!n_tok.first && !i_tok.last && (i_idx == i_last_idx)
                    && ($signed(i_tok.d) >= $signed(r_x))) begin
                n_tok.last = 1'b1;
                n_tok.yc   = r_y;
            end
            if (!i_tok.hit && (i_idx < i_last_idx)
                    && ($signed(i_tok.d) >= $signed(r_x))
                    && ($signed(i_tok.d) <= $signed(i_nx_x))) begin
                n_tok.hit = 1'b1;
                n_tok.x0  = r_x;
                n_tok.x1  = i_nx_x;
                n_tok.y0  = r_y;
                n_tok.y1  = i_nx_y;
            end
        end
    end

    // Hand the token to the neighbor.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_tok = r_tok;

endmodule

[hdl/pli_muldiv.sv]
module pli_muldiv (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [pli_pkg::VAL_W-1:0] i_a,
    input  logic [pli_pkg::VAL_W-1:0] i_b,
    input  logic [pli_pkg::VAL_W-1:0] i_w,
    input  logic [pli_pkg::VAL_W-1:0] i_y0,
    input  logic                      i_neg,
    output logic                      o_done,
    output logic [pli_pkg::VAL_W-1:0] o_value
);

    logic                         r_busy;
    logic                         r_done;
    logic [pli_pkg::STEP_W-1:0]   r_cnt;
    logic [pli_pkg::VAL_W-1:0]    r_a;
    logic [pli_pkg::VAL_W-1:0]    r_b;
    logic [pli_pkg::VAL_W-1:0]    r_w;
    logic [pli_pkg::VAL_W-1:0]    r_y0;
    logic                         r_neg;
    logic [pli_pkg::VAL_W+1:0]    r_r;
    logic [pli_pkg::VAL_W-1:0]    r_q;
    logic [pli_pkg::VAL_W+1:0]    n_r1;
    logic [pli_pkg::VAL_W+1:0]    n_r2;
    logic [pli_pkg::VAL_W+1:0]    n_r3;
    logic [1:0]                   n_dig;
    logic [pli_pkg::VAL_W+1:0]    w_ext;

    // One multiplier bit per step; the sum stays below three divisors, so the remainder stays below one.
    always_comb begin
        w_ext = {2'b00, r_w};
        n_r1  = {r_r[pli_pkg::VAL_W:0], 1'b0}
              + (r_b[pli_pkg::VAL_W-1] ? {2'b00, r_a} : '0);
        n_dig = 2'd0;
        n_r2  = n_r1;
        if (n_r1 >= w_ext) begin
            n_r2  = n_r1 - w_ext;
            n_dig = 2'd1;
        end
        n_r3 = n_r2;
        if (n_r2 >= w_ext) begin
            n_r3  = n_r2 - w_ext;
            n_dig = n_dig + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == pli_pkg::STEP_W'(pli_pkg::VAL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_w   <= i_w;
            r_y0  <= i_y0;
            r_neg <= i_neg;
            r_r   <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_b <= {r_b[pli_pkg::VAL_W-2:0], 1'b0};
            r_r <= n_r3;
            r_q <= {r_q[pli_pkg::VAL_W-2:0], 1'b0} + pli_pkg::VAL_W'(n_dig);
        end
    end

    assign o_done  = r_done;
    assign o_value = r_neg ? (r_y0 - r_q) : (r_y0 + r_q);

endmodule

[hdl/piecewise_linear_interpolator.sv]
// Channel  | Direction | Transfer payload
// s_axis   | in        | tuser: opcode; tdata: entry_index, entry_domain, entry_range,
//          |           |        query_point (lowest bits first, padded to 104)
// m_axis   | out       | tdata: interpolated_value
// apb      | in        | point_count at byte address 0
//
// A load leaves the block ready for the next item. A query walks the row of 32 cells, one cell per
// cycle, and one that falls inside an interval of nonzero width then runs 32 shift-and-subtract
// steps; the next item is taken only once its result has been loaded into the output register.
// Reset is synchronous and active low; table contents are not cleared. Input is taken
// only while no query is in flight; a finished result waits in the output register.
module piecewise_linear_interpolator (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [4:0] entry_index, [36:5] entry_domain, [68:37] entry_range,
    // [100:69] query_point, [103:101] zero
    input  logic [103:0] s_axis_tdata,
    // [0] opcode
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] interpolated_value
    output logic [31:0]  m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int VW = pli_pkg::VAL_W;
    localparam int NC = pli_pkg::NUM_CELLS;

    pli_pkg::t_state                r_state;
    pli_pkg::t_state                n_state;
    logic [pli_pkg::CNT_W-1:0]      r_pcount;
    logic [VW-1:0]                  r_res;
    logic [VW-1:0]                  n_res;
    logic                           r_ovalid;
    logic [VW-1:0]                  r_odata;
    logic                           accept;
    logic                           out_load;
    logic                           div_start;
    logic                           div_done;
    logic [VW-1:0]                  div_value;
    logic [pli_pkg::IDX_W-1:0]      last_idx;
    pli_pkg::t_wr                   wr;
    pli_pkg::t_tok                  w_tok [0:NC];
    logic [VW-1:0]                  w_x   [0:NC-1];
    logic [VW-1:0]                  w_y   [0:NC-1];
    pli_pkg::t_tok                  tend;
    logic [VW:0]                    dy;
    logic                           dy_neg;

    // Configuration register.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == pli_pkg::REG_POINT_COUNT)
                  ? {{(32 - pli_pkg::CNT_W){1'b0}}, r_pcount} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcount <= pli_pkg::CNT_W'(1);
        end else if (psel && penable && pwrite
                && (paddr[2] == pli_pkg::REG_POINT_COUNT)) begin
            r_pcount <= pwdata[pli_pkg::CNT_W-1:0];
        end
    end

    // Index of the last breakpoint in use, with zero and overrange clamped.
    always_comb begin
        if (r_pcount == '0) begin
            last_idx = '0;
        end else if (r_pcount > pli_pkg::CNT_W'(NC)) begin
            last_idx = pli_pkg::IDX_W'(NC - 1);
        end else begin
            last_idx = pli_pkg::IDX_W'(r_pcount - 1'b1);
        end
    end

    // Input side: loads broadcast, queries launch a token into cell zero.
    assign s_axis_tready = (r_state == pli_pkg::ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        wr.en  = accept && (s_axis_tuser == pli_pkg::OP_LOAD);
        wr.idx = s_axis_tdata[4:0];
        wr.x   = s_axis_tdata[36:5];
        wr.y   = s_axis_tdata[68:37];
        w_tok[0]       = '0;
        w_tok[0].valid = accept && (s_axis_tuser == pli_pkg::OP_QUERY);
        w_tok[0].d     = s_axis_tdata[100:69];
    end

    // Row of cells.
    genvar gi;
    generate
        for (gi = 0; gi < NC; gi++) begin : g_cell
            logic [VW-1:0] nx_x;
            logic [VW-1:0] nx_y;
            if (gi < NC - 1) begin : g_mid
                assign nx_x = w_x[gi+1];
                assign nx_y = w_y[gi+1];
            end else begin : g_end
                assign nx_x = '0;
                assign nx_y = '0;
            end
            pli_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_idx      (pli_pkg::IDX_W'(gi)),
                .i_last_idx (last_idx),
                .i_wr       (wr),
                .i_tok      (w_tok[gi]),
                .i_nx_x     (nx_x),
                .i_nx_y     (nx_y),
                .o_x        (w_x[gi]),
                .o_y        (w_y[gi]),
                .o_tok      (w_tok[gi+1])
            );
        end
    endgenerate

    // Interval operands from the token leaving the row.
    assign tend   = w_tok[NC];
    assign dy     = {tend.y1[VW-1], tend.y1} - {tend.y0[VW-1], tend.y0};
    assign dy_neg = dy[VW];

    pli_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_a     (tend.d - tend.x0),
        .i_b     (dy_neg ? (tend.y0 - tend.y1) : (tend.y1 - tend.y0)),
        .i_w     (tend.x1 - tend.x0),
        .i_y0    (tend.y0),
        .i_neg   (dy_neg),
        .o_done  (div_done),
        .o_value (div_value)
    );

    // Sequencer.
    always_comb begin
        n_state   = r_state;
        n_res     = r_res;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            pli_pkg::ST_IDLE: begin
                if (w_tok[0].valid) begin
                    n_state = pli_pkg::ST_SEARCH;
                end
            end
            pli_pkg::ST_SEARCH: begin
                if (tend.valid) begin
                    n_state = pli_pkg::ST_OUT;
                    if (tend.first || tend.last) begin
                        n_res = tend.yc;
                    end else if (tend.hit) begin
                        if (tend.x0 == tend.x1) begin
                            n_res = tend.y0;
                        end else begin
                            div_start = 1'b1;
                            n_state   = pli_pkg::ST_DIV;
                        end
                    end else begin
                        n_res = '0;
                    end
                end
            end
            pli_pkg::ST_DIV: begin
                if (div_done) begin
                    n_res   = div_value;
                    n_state = pli_pkg::ST_OUT;
                end
            end
            pli_pkg::ST_OUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = pli_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pli_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pli_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_odata <= r_res;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

endmodule

[bench/piecewise_linear_interpolator_tb.sv]
module piecewise_linear_interpolator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Breakpoint table model and the results it predicts.
    class interp_scoreboard;
        logic signed [31:0]         domain_tbl [pli_pkg::NUM_CELLS];
        logic signed [31:0]         range_tbl [pli_pkg::NUM_CELLS];
        logic [pli_pkg::CNT_W-1:0]  point_cnt;
        logic [31:0]                pending_values [$];
        int                         fail_count;

        function new();
            point_cnt = 1;
            fail_count = 0;
            for (int i = 0; i < pli_pkg::NUM_CELLS; i++) begin
                domain_tbl[i] = 0;
                range_tbl[i] = 0;
            end
        endfunction

        // Exact floor(a*b/w), with a at most w.
        function logic [63:0] scaled_quotient(logic [63:0] a, logic [63:0] b,
                                              logic [63:0] w);
            logic [63:0] q;
            logic [63:0] r;
            q = 0;
            r = 0;
            for (int bit_i = pli_pkg::VAL_W - 1; bit_i >= 0; bit_i--) begin
                q = q << 1;
                r = r << 1;
                if (b[bit_i]) r = r + a;
                while (r >= w) begin
                    r = r - w;
                    q = q + 1;
                end
            end
            return q;
        endfunction

        function logic signed [63:0] interpolate_at(logic signed [63:0] d);
            int n;
            logic signed [63:0] x0, x1, y0, y1;
            n = point_cnt;
            if (n == 0) n = 1;
            if (n > pli_pkg::NUM_CELLS) n = pli_pkg::NUM_CELLS;
            if (d <= domain_tbl[0]) return range_tbl[0];
            if (d >= domain_tbl[n-1]) return range_tbl[n-1];
            for (int i = 0; i + 1 < n; i++) begin
                x0 = domain_tbl[i];
                x1 = domain_tbl[i+1];
                y0 = range_tbl[i];
                y1 = range_tbl[i+1];
                if (d >= x0 && d <= x1) begin
                    if (x1 == x0) return y0;
                    if (y1 >= y0)
                        return y0 + scaled_quotient(d - x0, y1 - y0, x1 - x0);
                    return y0 - scaled_quotient(d - x0, y0 - y1, x1 - x0);
                end
            end
            return 0;
        endfunction

        // Note an accepted input transfer.
        function void note_item(logic op, logic [103:0] data);
            logic signed [63:0] v;
            if (op == pli_pkg::OP_LOAD) begin
                domain_tbl[data[4:0]] = data[36:5];
                range_tbl[data[4:0]] = data[68:37];
            end else begin
                v = interpolate_at($signed(data[100:69]));
                pending_values.push_back(v[31:0]);
            end
        endfunction

        // Compare an accepted output transfer with the oldest prediction.
        function void check_value(logic [31:0] got);
            logic [31:0] want;
            if (pending_values.size() == 0) begin
                $error("interpolated_value: none expected, actual %0d", $signed(got));
                fail_count++;
                return;
            end
            want = pending_values.pop_front();
            if (got !== want) begin
                $error("interpolated_value: expected %0d, actual %0d",
                       $signed(want), $signed(got));
                fail_count++;
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // [4:0] entry_index, [36:5] entry_domain, [68:37] entry_range, [100:69] query_point
    logic [103:0] s_axis_tdata;
    // [0] opcode
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // [31:0] interpolated_value
    logic [31:0]  m_axis_tdata;
    logic         psel, penable, pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    interp_scoreboard sb;
    bit           long_hold_req;
    int           table_size;
    logic signed [31:0] bp_domain [pli_pkg::NUM_CELLS];

    piecewise_linear_interpolator dut (.*);

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #8ms;
        $display("piecewise_linear_interpolator_tb: FAIL");
        $finish;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 4);
        return 0;
    endfunction

    // Offer one item and wait for its transfer; valid stays high for a following item.
    task automatic send_item(logic op, logic [4:0] idx, logic [31:0] x,
                             logic [31:0] y, logic [31:0] q, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'b000, q, y, x, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(op, {3'b000, q, y, x, idx});
    endtask

    task automatic load_point(int idx, logic [31:0] x, logic [31:0] y);
        send_item(pli_pkg::OP_LOAD, idx[4:0], x, y, $urandom, 1'b1);
    endtask

    task automatic query_point(logic [31:0] q);
        send_item(pli_pkg::OP_QUERY, 5'($urandom), $urandom, $urandom, q, 1'b1);
    endtask

    // Stop offering, wait for every prediction to be met, then let the block settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_values.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_point_count(logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= 3'(pli_pkg::REG_POINT_COUNT) << 2;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.point_cnt = value[pli_pkg::CNT_W-1:0];
    endtask

    // Load a non-decreasing table of n points with random spacing and values.
    task automatic load_table(int n, bit narrow);
        logic signed [63:0] x;
        logic [31:0] span;
        span = narrow ? 32'd1000 : (32'hFFFF_FFFF / n);
        x = narrow ? $signed($urandom_range(0, 2000)) - 1000 : -64'sd2147483648;
        for (int i = 0; i < n; i++) begin
            bp_domain[i] = x[31:0];
            load_point(i, x[31:0], $urandom);
            if ($urandom_range(0, 15) == 0) x = x;
            else x = x + $urandom_range(1, span);
            if (x > 64'sd2147483647) x = 64'sd2147483647;
        end
        table_size = n;
    endtask

    function automatic logic [31:0] pick_query();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return $urandom;
        if (k == 1) return bp_domain[$urandom_range(0, table_size - 1)];
        return bp_domain[$urandom_range(0, table_size - 1)]
               + $signed($urandom_range(0, 2000)) - 1000;
    endfunction

    // Receiver: random stalls plus one long hold-off on request.
    initial begin
        int g;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
                long_hold_req = 0;
            end else begin
                g = gap_len();
                if (g > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (g) @(posedge i_clk);
                end
            end
            m_axis_tready <= 1'b1;
        end
    end

    // Output monitor.
    always @(posedge i_clk)
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_value(m_axis_tdata);

    initial begin
        int n;
        int cnt;
        sb = new();
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = pli_pkg::OP_LOAD;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        long_hold_req = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: single point, then extremes of all fields.
        load_point(0, 32'sd100, 32'h7FFF_FFFF);
        query_point(32'h8000_0000);
        query_point(32'h7FFF_FFFF);
        load_point(1, 32'h7FFF_FFFF, 32'h8000_0000);
        load_point(2, 32'h7FFF_FFFF, 32'sd5);
        load_point(31, 32'h7FFF_FFFF, 32'h1234_5678);
        drain();
        write_point_count(0);
        query_point(32'sd100);
        drain();
        write_point_count(2);
        query_point(32'sd101);
        query_point(32'h7FFF_FFFE);
        query_point(32'sd100);
        drain();
        // Zero-width interval inside the table and a descending pair.
        load_point(0, 32'h8000_0000, 32'sd10);
        load_point(1, 32'sd0, 32'sd20);
        load_point(2, 32'sd0, 32'sd30);
        load_point(3, 32'sd50, 32'h8000_0000);
        load_point(4, -32'sd10, 32'sd7);
        drain();
        write_point_count(5);
        query_point(32'sd0);
        query_point(-32'sd1);
        query_point(32'sd20);
        drain();
        write_point_count(63);
        query_point(32'sd1);
        drain();

        // Random phases with varying table sizes.
        cnt = 0;
        for (int ph = 0; cnt < 1850; ph++) begin
            case (ph % 6)
                0: n = 32;
                1: n = 1;
                2: n = 2;
                default: n = $urandom_range(1, 32);
            endcase
            load_table(n, ph % 2);
            drain();
            write_point_count((ph % 9 == 0) ? 32'd0 + (n == 1 ? 0 : n)
                                            : ((n == 32 && ph % 4 == 0) ? 40 : n));
            if (ph == 3) long_hold_req = 1;
            for (int j = 0; j < 60; j++) begin
                if ($urandom_range(0, 15) == 0)
                    load_point($urandom_range(0, n - 1),
                               bp_domain[$urandom_range(0, n - 1)], $urandom);
                else
                    query_point(pick_query());
                cnt++;
            end
            cnt += n;
            drain();
        end

        if (sb.fail_count == 0 && sb.pending_values.size() == 0)
            $display("piecewise_linear_interpolator_tb: PASS");
        else
            $display("piecewise_linear_interpolator_tb: FAIL");
        $finish;
    end

endmodule
